>>> hw/rtl/bclru_pkg.sv
// Shared types and constants for the LRU block cache with pin bits.
// Used by the controller, the datapath and the top level.
`default_nettype none

package bclru_pkg;

    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;    // width of the slot fields on the ports

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_HIT      = 3'd0;
    localparam t_status ST_MISS     = 3'd1;
    localparam t_status ST_RANGE    = 3'd2;
    localparam t_status ST_FULL     = 3'd3;
    localparam t_status ST_PINNED   = 3'd4;
    localparam t_status ST_RELEASED = 3'd5;

    typedef struct packed {
        logic latch;    // capture the request word
        logic rd_en;    // issue a scan read
        logic commit;   // update state, register the result word
    } t_dp_cmd;

    typedef struct packed {
        logic skip_scan;    // release or out-of-range get at the input
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/bclru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bclru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bclru_ctrl.sv
// Sequencer for the cache: accept, slot scan, drain, commit.
// Depends on bclru_pkg.
`default_nettype none

module bclru_ctrl #(
    parameter int NUM_SLOTS = 16,
    localparam int SLOT_BITS = $clog2(NUM_SLOTS)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    output logic                        o_busy,
    input  wire bclru_pkg::t_dp_stat    i_stat,
    output bclru_pkg::t_dp_cmd          o_cmd,
    output logic [SLOT_BITS-1:0]        o_rd_addr
);

    import bclru_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_SLOTS - 1);

    logic [1:0]           r_state, n_state;
    logic [SLOT_BITS-1:0] r_cnt, n_cnt;
    logic                 accept;

    assign accept    = i_start && (r_state == S_IDLE);
    assign o_busy    = (r_state != S_IDLE);
    assign o_rd_addr = r_cnt;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd.latch  = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    n_cnt       = '0;
                    n_state     = i_stat.skip_scan ? S_RESP : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_cnt == LAST_SLOT) begin
                    n_state = S_LAST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_LAST: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bclru_dp.sv
// Datapath: tag and stamp RAMs, valid/pin bits, scan compare, result word.
// Depends on bclru_pkg and bclru_ram.
`default_nettype none

module bclru_dp #(
    parameter int NUM_SLOTS       = 16,
    parameter int BLOCK_ADDR_BITS = 10,
    localparam int SLOT_BITS = $clog2(NUM_SLOTS)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bclru_pkg::t_dp_cmd           i_cmd,
    input  wire logic [SLOT_BITS-1:0]         i_rd_addr,
    output bclru_pkg::t_dp_stat               o_stat,
    input  wire logic                         i_cfg_we,
    input  wire logic [BLOCK_ADDR_BITS:0]     i_cfg_wdata,
    input  wire logic                         i_mode,
    input  wire logic [BLOCK_ADDR_BITS-1:0]   i_block_number,
    input  wire logic [bclru_pkg::SLOT_W-1:0] i_release_slot,
    output logic                              o_done,
    output bclru_pkg::t_status                o_status,
    output logic [bclru_pkg::SLOT_W-1:0]      o_granted_slot,
    output logic                              o_writeback_needed,
    output logic [BLOCK_ADDR_BITS-1:0]        o_writeback_block
);

    import bclru_pkg::*;

    localparam int RW = (SLOT_BITS > SLOT_W) ? SLOT_BITS : SLOT_W;
    localparam logic [BLOCK_ADDR_BITS:0] DISK_RST = {1'b1, {BLOCK_ADDR_BITS{1'b0}}};

    logic [BLOCK_ADDR_BITS:0]   r_disk_blocks;
    logic [NUM_SLOTS-1:0]       r_valid;
    logic [NUM_SLOTS-1:0]       r_pinned;
    logic [STAMP_W-1:0]         r_use;

    logic                       r_mode;
    logic                       r_range;
    logic [BLOCK_ADDR_BITS-1:0] r_bno;
    logic [SLOT_W-1:0]          r_rel;

    logic                       r_cmp_vld;
    logic [SLOT_BITS-1:0]       r_cmp_idx;
    logic                       r_hit;
    logic [SLOT_BITS-1:0]       r_hit_idx;
    logic                       r_vic;
    logic [SLOT_BITS-1:0]       r_vic_idx;
    logic [STAMP_W-1:0]         r_vic_stamp;
    logic                       r_vic_wb;
    logic [BLOCK_ADDR_BITS-1:0] r_vic_tag;

    logic                       r_out_vld;
    t_status                    r_out_status;
    logic [SLOT_W-1:0]          r_out_slot;
    logic                       r_out_wb;
    logic [BLOCK_ADDR_BITS-1:0] r_out_wb_block;

    logic [BLOCK_ADDR_BITS-1:0] tag_q;
    logic [STAMP_W-1:0]         stamp_q;
    logic [STAMP_W-1:0]         cur_stamp;
    logic                       cur_valid;
    logic                       cur_pin;
    logic                       hit_now;
    logic                       vic_now;
    logic                       in_range_fail;

    logic [STAMP_W-1:0]         n_use;
    logic [RW-1:0]              rel_ext;
    logic [SLOT_BITS-1:0]       rel_idx;
    logic                       rel_ok;
    logic                       hit_ok;
    logic                       miss_ok;
    logic                       tag_we;
    logic                       stamp_we;
    logic [SLOT_BITS-1:0]       wr_idx;
    logic [RW-1:0]              wr_idx_ext;

    // scan compare
    assign in_range_fail    = ({1'b0, i_block_number} >= r_disk_blocks);
    assign o_stat.skip_scan = i_mode || in_range_fail;

    assign cur_valid = r_valid[r_cmp_idx];
    assign cur_pin   = r_pinned[r_cmp_idx];
    assign cur_stamp = cur_valid ? stamp_q : '0;
    assign hit_now   = r_cmp_vld && !r_hit && cur_valid && (tag_q == r_bno);
    assign vic_now   = r_cmp_vld && !cur_pin && (!r_vic || (cur_stamp < r_vic_stamp));

    // commit decode
    assign n_use      = r_use + 1'b1;
    assign rel_ext    = RW'(r_rel);
    assign rel_idx    = rel_ext[SLOT_BITS-1:0];
    assign rel_ok     = (32'(r_rel) < NUM_SLOTS);
    assign hit_ok     = !r_mode && !r_range && r_hit && !r_pinned[r_hit_idx];
    assign miss_ok    = !r_mode && !r_range && !r_hit && r_vic;
    assign wr_idx     = r_hit ? r_hit_idx : r_vic_idx;
    assign wr_idx_ext = RW'(wr_idx);
    assign tag_we     = i_cmd.commit && miss_ok;
    assign stamp_we   = i_cmd.commit && (hit_ok || miss_ok);

    bclru_ram #(
        .WIDTH (BLOCK_ADDR_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (wr_idx),
        .i_wdata (r_bno),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (tag_q)
    );

    bclru_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (NUM_SLOTS)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (wr_idx),
        .i_wdata (n_use),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (stamp_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_blocks <= DISK_RST;
            r_valid       <= '0;
            r_pinned      <= '0;
            r_use         <= '0;
            r_cmp_vld     <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_disk_blocks <= i_cfg_wdata;
            end
            r_cmp_vld <= i_cmd.rd_en;
            r_out_vld <= i_cmd.commit;
            if (i_cmd.commit) begin
                if (r_mode) begin
                    if (rel_ok) begin
                        r_pinned[rel_idx] <= 1'b0;
                    end
                end else if (hit_ok || miss_ok) begin
                    r_valid[wr_idx]  <= 1'b1;
                    r_pinned[wr_idx] <= 1'b1;
                    r_use            <= n_use;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode  <= i_mode;
            r_range <= in_range_fail;
            r_bno   <= i_block_number;
            r_rel   <= i_release_slot;
            r_hit   <= 1'b0;
            r_vic   <= 1'b0;
        end else begin
            if (hit_now) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
            end
            if (vic_now) begin
                r_vic       <= 1'b1;
                r_vic_idx   <= r_cmp_idx;
                r_vic_stamp <= cur_stamp;
                r_vic_wb    <= cur_valid;
                r_vic_tag   <= tag_q;
            end
        end
        if (i_cmd.rd_en) begin
            r_cmp_idx <= i_rd_addr;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_slot     <= '0;
            r_out_wb       <= 1'b0;
            r_out_wb_block <= '0;
            if (r_mode) begin
                r_out_status <= ST_RELEASED;
            end else if (r_range) begin
                r_out_status <= ST_RANGE;
            end else if (r_hit) begin
                if (hit_ok) begin
                    r_out_status <= ST_HIT;
                    r_out_slot   <= wr_idx_ext[SLOT_W-1:0];
                end else begin
                    r_out_status <= ST_PINNED;
                end
            end else if (!r_vic) begin
                r_out_status <= ST_FULL;
            end else begin
                r_out_status <= ST_MISS;
                r_out_slot   <= wr_idx_ext[SLOT_W-1:0];
                r_out_wb     <= r_vic_wb;
                if (r_vic_wb) begin
                    r_out_wb_block <= r_vic_tag;
                end
            end
        end
    end

    assign o_done             = r_out_vld;
    assign o_status           = r_out_status;
    assign o_granted_slot     = r_out_slot;
    assign o_writeback_needed = r_out_wb;
    assign o_writeback_block  = r_out_wb_block;

    a_use_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (o_status == ST_HIT || o_status == ST_MISS))
            |-> (r_use == $past(r_use) + 1'b1))
        else $error("use counter did not advance on a grant");

    a_use_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && o_status != ST_HIT && o_status != ST_MISS)
            |-> (r_use == $past(r_use)))
        else $error("use counter moved on a non-grant");

    a_wb_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && o_writeback_needed) |-> (o_status == ST_MISS))
        else $error("write-back flagged outside a miss");

    a_ram_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tag_we |-> (stamp_we && !r_valid[wr_idx] || stamp_we && !r_pinned[wr_idx]))
        else $error("tag write into a pinned slot");

endmodule

`default_nettype wire

>>> hw/rtl/block_cache_lru_with_pinning_unit.sv
// Top level of the LRU block cache tag/replacement controller with pin bits.
// Depends on bclru_pkg, bclru_ctrl, bclru_dp (which uses bclru_ram).
//
// channel   direction  handshake                 word
// request   in         i_start & !o_busy         i_mode, i_block_number, i_release_slot
// result    out        o_done (one-cycle strobe) o_status, o_granted_slot,
//                                                o_writeback_needed, o_writeback_block
// config    in         i_cfg_we                  i_cfg_wdata (disk_blocks)
//
// A get scans every slot, reading one slot per cycle from the tag and stamp RAMs,
// then drains the last read and commits. A release or an out-of-range get skips
// the scan and goes straight to commit. o_busy is high from the cycle after accept
// until the commit cycle; a new request may start while o_done is shown.
// Synchronous active-low reset clears valid and pin bits, the use counter and
// sets disk_blocks to 2**BLOCK_ADDR_BITS. The result receiver cannot stall.
`default_nettype none

module block_cache_lru_with_pinning_unit #(
    parameter int NUM_SLOTS       = 16,
    parameter int BLOCK_ADDR_BITS = 10
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic                         i_mode,
    input  wire logic [BLOCK_ADDR_BITS-1:0]   i_block_number,
    input  wire logic [bclru_pkg::SLOT_W-1:0] i_release_slot,
    input  wire logic                         i_cfg_we,
    input  wire logic [BLOCK_ADDR_BITS:0]     i_cfg_wdata,
    output logic                              o_done,
    output bclru_pkg::t_status                o_status,
    output logic [bclru_pkg::SLOT_W-1:0]      o_granted_slot,
    output logic                              o_writeback_needed,
    output logic [BLOCK_ADDR_BITS-1:0]        o_writeback_block
);

    import bclru_pkg::*;

    localparam int SLOT_BITS = $clog2(NUM_SLOTS);

    t_dp_cmd              dp_cmd;
    t_dp_stat             dp_stat;
    logic [SLOT_BITS-1:0] rd_addr;

    bclru_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .o_busy    (o_busy),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .o_rd_addr (rd_addr)
    );

    bclru_dp #(
        .NUM_SLOTS       (NUM_SLOTS),
        .BLOCK_ADDR_BITS (BLOCK_ADDR_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .i_rd_addr          (rd_addr),
        .o_stat             (dp_stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_mode             (i_mode),
        .i_block_number     (i_block_number),
        .i_release_slot     (i_release_slot),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_granted_slot     (o_granted_slot),
        .o_writeback_needed (o_writeback_needed),
        .o_writeback_block  (o_writeback_block)
    );

endmodule

`default_nettype wire

>>> verif/block_cache_lru_with_pinning_unit_tb.sv
// Self-checking testbench for the LRU block cache tag controller with pin bits.
// Holds its own copy of tags, valid/pin bits and use stamps to predict each result word.
// Depends on bclru_pkg and block_cache_lru_with_pinning_unit.
module block_cache_lru_with_pinning_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bclru_pkg::*;

    localparam int SLOTS  = 16;
    localparam int ADDR_W = 10;

    localparam logic MODE_GET     = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [ADDR_W:0] DISK_FULL_SIZE = 11'd1024;
    localparam logic [ADDR_W:0] DISK_MAX_SIZE  = 11'd2047;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic              wb_needed;
        logic [ADDR_W-1:0] wb_block;
    } t_cache_reply;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_start        = 1'b0;
    logic                i_mode         = 1'b0;
    logic [ADDR_W-1:0]   i_block_number = '0;
    logic [SLOT_W-1:0]   i_release_slot = '0;
    logic                i_cfg_we       = 1'b0;
    logic [ADDR_W:0]     i_cfg_wdata    = '0;
    logic                o_busy;
    logic                o_done;
    t_status             o_status;
    logic [SLOT_W-1:0]   o_granted_slot;
    logic                o_writeback_needed;
    logic [ADDR_W-1:0]   o_writeback_block;

    // mirror of the cache directory
    logic [ADDR_W-1:0]   tag_mirror   [SLOTS];
    logic                valid_mirror [SLOTS];
    logic                pin_mirror   [SLOTS];
    logic [31:0]         stamp_mirror [SLOTS];
    logic [31:0]         use_count;
    logic [ADDR_W:0]     disk_size;

    t_cache_reply        pending_replies[$];
    int                  failures    = 0;
    int                  words_sent  = 0;
    int                  writebacks  = 0;
    int                  status_seen [8];

    block_cache_lru_with_pinning_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_mode             (i_mode),
        .i_block_number     (i_block_number),
        .i_release_slot     (i_release_slot),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_granted_slot     (o_granted_slot),
        .o_writeback_needed (o_writeback_needed),
        .o_writeback_block  (o_writeback_block)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_cache_reply resolve_request(logic mode, logic [ADDR_W-1:0] bno,
                                                     logic [SLOT_W-1:0] rel);
        t_cache_reply r;
        int hit;
        int victim;
        r      = '0;
        hit    = -1;
        victim = -1;
        if (mode == MODE_RELEASE) begin
            pin_mirror[rel] = 1'b0;
            r.status = ST_RELEASED;
            return r;
        end
        if ({1'b0, bno} >= disk_size) begin
            r.status = ST_RANGE;
            return r;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && valid_mirror[i] && tag_mirror[i] == bno) hit = i;
        end
        if (hit >= 0) begin
            if (pin_mirror[hit]) begin
                r.status = ST_PINNED;
                return r;
            end
            use_count         = use_count + 32'd1;
            stamp_mirror[hit] = use_count;
            pin_mirror[hit]   = 1'b1;
            r.status = ST_HIT;
            r.slot   = SLOT_W'(hit);
            return r;
        end
        // oldest unpinned stamp, lowest index on ties
        for (int i = 0; i < SLOTS; i++) begin
            if (!pin_mirror[i] && (victim < 0 || stamp_mirror[i] < stamp_mirror[victim]))
                victim = i;
        end
        if (victim < 0) begin
            r.status = ST_FULL;
            return r;
        end
        if (valid_mirror[victim]) begin
            r.wb_needed = 1'b1;
            r.wb_block  = tag_mirror[victim];
        end
        tag_mirror[victim]   = bno;
        valid_mirror[victim] = 1'b1;
        use_count            = use_count + 32'd1;
        stamp_mirror[victim] = use_count;
        pin_mirror[victim]   = 1'b1;
        r.status = ST_MISS;
        r.slot   = SLOT_W'(victim);
        return r;
    endfunction

    function automatic void flag_failure(string what, t_cache_reply want, t_cache_reply got);
        failures++;
        if (failures <= 10)
            $display({"%0t: %s: exp status %0d slot %0d wb %0b blk %0d, ",
                      "got status %0d slot %0d wb %0b blk %0d"},
                     $realtime, what, want.status, want.slot, want.wb_needed, want.wb_block,
                     got.status, got.slot, got.wb_needed, got.wb_block);
    endfunction

    always @(posedge i_clk) begin : reply_check
        t_cache_reply got;
        t_cache_reply want;
        if (i_rst_n && o_done) begin
            got = {o_status, o_granted_slot, o_writeback_needed, o_writeback_block};
            if (pending_replies.size() == 0) begin
                flag_failure("unexpected word", '0, got);
            end else begin
                want = pending_replies.pop_front();
                if (got !== want) flag_failure("mismatch", want, got);
                if (got.status <= ST_RELEASED) status_seen[got.status]++;
                if (got.wb_needed === 1'b1) writebacks++;
            end
        end
    end

    // leaves i_start high; the next call or an idle drops or reuses it at a falling edge
    task automatic send_word(logic mode, logic [ADDR_W-1:0] bno, logic [SLOT_W-1:0] rel);
        @(negedge i_clk);
        i_start        = 1'b1;
        i_mode         = mode;
        i_block_number = bno;
        i_release_slot = rel;
        do @(posedge i_clk); while (o_busy);
        pending_replies.push_back(resolve_request(mode, bno, rel));
        words_sent++;
    endtask

    task automatic get_block(logic [ADDR_W-1:0] bno);
        send_word(MODE_GET, bno, SLOT_W'($urandom));
    endtask

    task automatic release_slot(logic [SLOT_W-1:0] rel);
        send_word(MODE_RELEASE, ADDR_W'($urandom), rel);
    endtask

    // the gap is counted once the block is ready again
    task automatic idle_for(int cycles);
        @(negedge i_clk);
        i_start = 1'b0;
        while (o_busy) @(negedge i_clk);
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_disk_blocks(logic [ADDR_W:0] blocks);
        settle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = blocks;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        disk_size   = blocks;
    endtask

    task automatic test_empty_cache();
        get_block(10'd0);       // empty slots must not match block 0
        get_block(10'd0);
        get_block(10'd1023);
        release_slot(4'd0);
        release_slot(4'd0);     // already unpinned
        get_block(10'd0);
    endtask

    task automatic test_pinning_and_full();
        for (int b = 2; b < SLOTS; b++) get_block(ADDR_W'(b));
        get_block(10'd100);     // every slot pinned
        release_slot(4'd15);
        get_block(10'd200);     // evicts block 15
    endtask

    task automatic test_disk_limit();
        write_disk_blocks(11'd5);
        get_block(10'd5);       // cached, still out of range
        write_disk_blocks(11'd0);
        get_block(10'd0);
        write_disk_blocks(11'd1);
        get_block(10'd1);
        write_disk_blocks(DISK_MAX_SIZE);
        release_slot(4'd5);
        get_block(10'd5);
    endtask

    task automatic test_random_traffic(logic [ADDR_W:0] blocks, int count,
                                       logic [ADDR_W-1:0] base, int span, bit gaps);
        int pick;
        int held[$];
        write_disk_blocks(blocks);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            held = {};
            for (int i = 0; i < SLOTS; i++) if (pin_mirror[i]) held.push_back(i);
            if (pick < 45)
                get_block(ADDR_W'(base + $urandom_range(0, span - 1)));
            else if (pick < 55)
                get_block(ADDR_W'($urandom_range(0, 1023)));
            else if (pick < 90 && held.size() > 0)
                release_slot(SLOT_W'(held[$urandom_range(0, held.size() - 1)]));
            else
                release_slot(SLOT_W'($urandom_range(0, SLOTS - 1)));
            if (gaps && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 11));
        end
    endtask

    initial begin
        int waited;
        for (int i = 0; i < SLOTS; i++) begin
            tag_mirror[i]   = '0;
            valid_mirror[i] = 1'b0;
            pin_mirror[i]   = 1'b0;
            stamp_mirror[i] = '0;
        end
        for (int i = 0; i < 8; i++) status_seen[i] = 0;
        use_count = '0;
        disk_size = DISK_FULL_SIZE;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_cache();
        test_pinning_and_full();
        test_disk_limit();
        test_random_traffic(DISK_FULL_SIZE, 300, 10'd0, 24, 1'b1);
        test_random_traffic(11'($urandom_range(16, 1024)), 250, 10'd0, 24, 1'b1);
        test_random_traffic(DISK_MAX_SIZE, 250, 10'd1000, 24, 1'b1);
        test_random_traffic(11'd20, 250, 10'd0, 24, 1'b0);

        @(negedge i_clk);
        i_start = 1'b0;
        waited  = 0;
        while (pending_replies.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (25) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            failures += pending_replies.size();
            $display("%0d result words never arrived", pending_replies.size());
        end

        $display("sent %0d words: %0d hits, %0d fills (%0d write-backs), %0d releases",
                 words_sent, status_seen[ST_HIT], status_seen[ST_MISS], writebacks,
                 status_seen[ST_RELEASED]);
        $display("errors seen: %0d out of range, %0d all pinned, %0d already pinned",
                 status_seen[ST_RANGE], status_seen[ST_FULL], status_seen[ST_PINNED]);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> block_cache_lru_with_pinning_unit.f
hw/rtl/bclru_pkg.sv
hw/rtl/bclru_ram.sv
hw/rtl/bclru_ctrl.sv
hw/rtl/bclru_dp.sv
hw/rtl/block_cache_lru_with_pinning_unit.sv
verif/block_cache_lru_with_pinning_unit_tb.sv
